// File: sv/salcp_pkg.sv
// shared types and codes for the suffix array and lcp engine
`default_nettype none
package salcp_pkg;

  localparam int FIELD_W = 13;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] KIND_BUILD  = 2'd0;
  localparam logic [1:0] KIND_ANSWER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [7:0]         text_char;
    logic               last_char;
    logic [FIELD_W-1:0] pos_a;
    logic [FIELD_W-1:0] pos_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] lcp_len;
    logic [FIELD_W-1:0] rank_a;
    logic [FIELD_W-1:0] rank_b;
    logic [FIELD_W-1:0] text_len;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_INIT_RD, S_INIT_WR,
    S_CLR, S_HIST_RD, S_HIST_CNT, S_HIST_WR, S_PFX_RD, S_PFX_WR,
    S_SCAT_RD, S_SCAT_RANK, S_SCAT_CNT, S_SCAT_WR,
    S_JCHK, S_G1, S_G2_RD, S_G2_WR, S_COPY_RD, S_COPY_WR,
    S_RR_SA, S_RR_T, S_RR_TJ, S_RR_WR, S_DBL,
    S_K_RANK, S_K_SA, S_K_Y, S_K_CHK, S_K_TA, S_K_TB, S_K_WR,
    S_M0_SA, S_M0_H, S_M0_WR, S_MK_CHK, S_MK_A, S_MK_B, S_MK_WR,
    S_DONE,
    S_Q_CHK, S_Q_RA, S_Q_RB, S_Q_K, S_Q_M1, S_Q_M2, S_Q_OUT
  } state_t;

endpackage
`default_nettype wire

// File: sv/suffix_array_lcp_engine.sv
// top level: text load, suffix array build sequencer, lcp query unit
`default_nettype none
// Text bytes are loaded one per transaction (positions from 1); a load gives
// no result unless it carries the last mark. The last byte starts the
// build: prefix doubling with counting-sort passes, Kasai heights and a
// sparse min table, all held in single-read-port memories with registered
// reads, so the build runs as a sequencer of memory accesses. Each of the
// floor(log2 n) + 1 doubling rounds adds one more sort pass to the first
// one (a sort pass clears span = max(n, 256) buckets), and Kasai compares
// at most about 3*n bytes. A query in error gives its result without
// reading any table; equal positions read the rank table only, and an
// answer for other positions also reads the min table. No item is taken
// during a build or query; a result waits in an output register and loads
// are still taken meanwhile.
module suffix_array_lcp_engine #(
  parameter int MAX_LEN = 4096,
  parameter int LEVELS  = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire salcp_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output salcp_pkg::out_item_t       out_data
);
  import salcp_pkg::*;

  localparam int W   = ($clog2(MAX_LEN + 1) > 9) ? $clog2(MAX_LEN + 1) : 9;
  localparam int XW  = (W > FIELD_W) ? W : FIELD_W;
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LW1 = $clog2(LEVELS + 1);
  localparam int DEPTH = 1 << W;
  localparam int MDEPTH = 1 << (LW + W);

  // control registers
  state_t state, state_next, ret, ret_next;
  logic [W:0]   i, i_next, j, j_next;
  logic [W-1:0] tot, tot_next, acc, acc_next, sp, sp_next, sr, sr_next;
  logic [W-1:0] tp, tp_next, op, op_next, tq, tq_next;
  logic [W-1:0] prev, prev_next, len, len_next, yy, yy_next, ma, ma_next;
  logic [7:0]   ych, ych_next;
  logic [LW1-1:0] lvl, lvl_next;
  logic [FIELD_W-1:0] qa, qa_next, qb, qb_next;
  logic [W-1:0] ra, ra_next, rb, rb_next, qx, qx_next, qy, qy_next;
  logic [W-1:0] count, count_next;
  logic         built, built_next;
  logic         out_load;
  out_item_t    out_item;

  // memory ports
  logic           t_we;  logic [W-1:0] t_wa, t_ra; logic [7:0] t_wd, t_rd;
  logic           s_we;  logic [W-1:0] s_wa, s_wd, s_ra, s_rd;
  logic           r_we;  logic [W-1:0] r_wa, r_wd, r_ra, r_rd;
  logic           m_we;  logic [W-1:0] m_wa, m_wd, m_ra, m_rd;
  logic           c_we;  logic [W-1:0] c_wa, c_wd, c_ra, c_rd;
  logic           h_we;  logic [W-1:0] h_wa, h_wd, h_ra, h_rd;
  logic           n_we;  logic [LW+W-1:0] n_wa, n_ra; logic [W-1:0] n_wd, n_rd;

  salcp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_text (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_sa (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_rank (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_temp (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_height (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  salcp_ram #(.WIDTH(W), .DEPTH(MDEPTH)) u_min (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

  // floor log2 of a rank distance, clamped to the top level
  function automatic logic [LW1-1:0] lvl_of(input logic [W-1:0] d);
    int r;
    r = 0;
    for (int b = 0; b < W; b++) begin
      if (d[b]) r = b;
    end
    if (r > LEVELS - 1) r = LEVELS - 1;
    return LW1'(r);
  endfunction

  logic [W-1:0] span, base, step_w;
  logic [W:0]   n1, step, i_len, y_len, q_j;
  logic         q_bad, same;
  logic [W-1:0] oq;

  assign in_ready = (state == S_IDLE);

  // sequencer: next state, memory controls
  always_comb begin
    state_next = state; ret_next = ret; i_next = i; j_next = j;
    tot_next = tot; acc_next = acc; sp_next = sp; sr_next = sr;
    tp_next = tp; op_next = op; tq_next = tq; prev_next = prev; len_next = len;
    yy_next = yy; ma_next = ma; ych_next = ych; lvl_next = lvl;
    qa_next = qa; qb_next = qb; ra_next = ra; rb_next = rb; qx_next = qx; qy_next = qy;
    count_next = count; built_next = built;
    out_load = 1'b0; out_item = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;

    span   = (count > W'(256)) ? count : W'(256);
    base   = built ? '0 : count;
    n1     = (W+1)'(count);
    step   = (W+1)'(1) << (lvl - LW1'(1));
    step_w = W'(step);
    i_len  = i + (W+1)'(len);
    y_len  = (W+1)'(yy) + (W+1)'(len);
    q_j    = (W+1)'(sp) + j;
    oq     = (q_j <= n1) ? m_rd : '0;
    same   = (i != (W+1)'(1)) && (tq == tp) && (oq == op);
    q_bad  = !built || (qa == '0) || (XW'(qa) > XW'(count)) ||
             (qb == '0) || (XW'(qb) > XW'(count));

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_LOAD) begin
            built_next = 1'b0;
            count_next = base;
            if (base < W'(MAX_LEN)) begin
              count_next = base + W'(1);
              t_we = 1'b1;
              t_wa = base + W'(1);
              t_wd = in_data.text_char;
            end
            if (in_data.last_char) begin
              i_next = (W+1)'(1);
              state_next = S_INIT_RD;
            end
          end else begin
            qa_next = in_data.pos_a;
            qb_next = in_data.pos_b;
            state_next = S_Q_CHK;
          end
        end
      end
      // initial ranks from the bytes
      S_INIT_RD: begin
        t_ra = i[W-1:0];
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        r_we = 1'b1; r_wa = i[W-1:0]; r_wd = W'(t_rd) + W'(1);
        m_we = 1'b1; m_wa = i[W-1:0]; m_wd = i[W-1:0];
        if (i == n1) begin
          ret_next = S_JCHK;
          j_next = (W+1)'(1);
          i_next = '0;
          state_next = S_CLR;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_INIT_RD;
        end
      end
      // counting sort: clear buckets
      S_CLR: begin
        c_we = 1'b1; c_wa = i[W-1:0]; c_wd = '0;
        if (i == (W+1)'(span)) begin
          i_next = (W+1)'(1);
          state_next = S_HIST_RD;
        end else begin
          i_next = i + (W+1)'(1);
        end
      end
      // histogram of ranks
      S_HIST_RD: begin
        r_ra = i[W-1:0];
        state_next = S_HIST_CNT;
      end
      S_HIST_CNT: begin
        sr_next = r_rd;
        c_ra = r_rd;
        state_next = S_HIST_WR;
      end
      S_HIST_WR: begin
        c_we = 1'b1; c_wa = sr; c_wd = c_rd + W'(1);
        if (i == n1) begin
          i_next = (W+1)'(1);
          acc_next = '0;
          state_next = S_PFX_RD;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_HIST_RD;
        end
      end
      // running prefix sum
      S_PFX_RD: begin
        c_ra = i[W-1:0];
        state_next = S_PFX_WR;
      end
      S_PFX_WR: begin
        c_we = 1'b1; c_wa = i[W-1:0]; c_wd = acc + c_rd;
        acc_next = acc + c_rd;
        if (i == (W+1)'(span)) begin
          i_next = n1;
          state_next = S_SCAT_RD;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_PFX_RD;
        end
      end
      // scatter in reverse second-key order
      S_SCAT_RD: begin
        m_ra = i[W-1:0];
        state_next = S_SCAT_RANK;
      end
      S_SCAT_RANK: begin
        sp_next = m_rd;
        r_ra = m_rd;
        state_next = S_SCAT_CNT;
      end
      S_SCAT_CNT: begin
        sr_next = r_rd;
        c_ra = r_rd;
        state_next = S_SCAT_WR;
      end
      S_SCAT_WR: begin
        s_we = 1'b1; s_wa = c_rd; s_wd = sp;
        c_we = 1'b1; c_wa = sr; c_wd = c_rd - W'(1);
        if (i == (W+1)'(1)) begin
          state_next = ret;
        end else begin
          i_next = i - (W+1)'(1);
          state_next = S_SCAT_RD;
        end
      end
      // doubling round check
      S_JCHK: begin
        if (j <= n1) begin
          i_next = n1 - j + (W+1)'(1);
          tot_next = '0;
          state_next = S_G1;
        end else begin
          i_next = (W+1)'(1);
          prev_next = '0;
          state_next = S_K_RANK;
        end
      end
      // second key order: tail suffixes first
      S_G1: begin
        m_we = 1'b1; m_wa = tot + W'(1); m_wd = i[W-1:0];
        tot_next = tot + W'(1);
        if (i == n1) begin
          i_next = (W+1)'(1);
          state_next = S_G2_RD;
        end else begin
          i_next = i + (W+1)'(1);
        end
      end
      S_G2_RD: begin
        s_ra = i[W-1:0];
        state_next = S_G2_WR;
      end
      S_G2_WR: begin
        if ((W+1)'(s_rd) > j) begin
          m_we = 1'b1; m_wa = tot + W'(1); m_wd = W'((W+1)'(s_rd) - j);
          tot_next = tot + W'(1);
        end
        if (i == n1) begin
          ret_next = S_COPY_RD;
          i_next = '0;
          state_next = S_CLR;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_G2_RD;
        end
      end
      // save old ranks
      S_COPY_RD: begin
        r_ra = i[W-1:0];
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        m_we = 1'b1; m_wa = i[W-1:0]; m_wd = r_rd;
        if (i == n1) begin
          i_next = (W+1)'(1);
          tot_next = '0;
          state_next = S_RR_SA;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_COPY_RD;
        end
      end
      // new ranks from pairs of old ranks
      S_RR_SA: begin
        s_ra = i[W-1:0];
        state_next = S_RR_T;
      end
      S_RR_T: begin
        sp_next = s_rd;
        m_ra = s_rd;
        state_next = S_RR_TJ;
      end
      S_RR_TJ: begin
        tq_next = m_rd;
        m_ra = q_j[W-1:0];
        state_next = S_RR_WR;
      end
      S_RR_WR: begin
        r_we = 1'b1; r_wa = sp;
        r_wd = same ? tot : tot + W'(1);
        tot_next = same ? tot : tot + W'(1);
        tp_next = tq;
        op_next = oq;
        if (i == n1) begin
          state_next = S_DBL;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_RR_SA;
        end
      end
      S_DBL: begin
        j_next = j << 1;
        state_next = S_JCHK;
      end
      // kasai height array
      S_K_RANK: begin
        r_ra = i[W-1:0];
        state_next = S_K_SA;
      end
      S_K_SA: begin
        if (r_rd == W'(1)) begin
          len_next = '0;
          state_next = S_K_WR;
        end else begin
          s_ra = r_rd - W'(1);
          len_next = (prev != '0) ? prev - W'(1) : '0;
          state_next = S_K_Y;
        end
      end
      S_K_Y: begin
        yy_next = s_rd;
        state_next = S_K_CHK;
      end
      S_K_CHK: begin
        if (i_len <= n1 && y_len <= n1) begin
          t_ra = i_len[W-1:0];
          state_next = S_K_TA;
        end else begin
          state_next = S_K_WR;
        end
      end
      S_K_TA: begin
        ych_next = t_rd;
        t_ra = y_len[W-1:0];
        state_next = S_K_TB;
      end
      S_K_TB: begin
        if (t_rd == ych) begin
          len_next = len + W'(1);
          state_next = S_K_CHK;
        end else begin
          state_next = S_K_WR;
        end
      end
      S_K_WR: begin
        h_we = 1'b1; h_wa = i[W-1:0]; h_wd = len;
        prev_next = len;
        if (i == n1) begin
          i_next = (W+1)'(1);
          state_next = S_M0_SA;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_K_RANK;
        end
      end
      // sparse table level zero: heights in rank order
      S_M0_SA: begin
        s_ra = i[W-1:0];
        state_next = S_M0_H;
      end
      S_M0_H: begin
        h_ra = s_rd;
        state_next = S_M0_WR;
      end
      S_M0_WR: begin
        n_we = 1'b1; n_wa = {LW'(0), i[W-1:0]}; n_wd = h_rd;
        if (i == n1) begin
          lvl_next = LW1'(1);
          state_next = S_MK_CHK;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_M0_SA;
        end
      end
      // higher levels
      S_MK_CHK: begin
        if (lvl < LW1'(LEVELS) && (n1 >> lvl) != '0) begin
          i_next = (W+1)'(1);
          state_next = S_MK_A;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MK_A: begin
        n_ra = {LW'(lvl - LW1'(1)), i[W-1:0]};
        state_next = S_MK_B;
      end
      S_MK_B: begin
        n_ra = {LW'(lvl - LW1'(1)), i[W-1:0] + step_w};
        ma_next = n_rd;
        state_next = S_MK_WR;
      end
      S_MK_WR: begin
        n_we = 1'b1; n_wa = {LW'(lvl), i[W-1:0]};
        n_wd = (ma < n_rd) ? ma : n_rd;
        if (i + (W+1)'(1) + step > n1) begin
          lvl_next = lvl + LW1'(1);
          state_next = S_MK_CHK;
        end else begin
          i_next = i + (W+1)'(1);
          state_next = S_MK_A;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          out_item.kind = KIND_BUILD;
          out_item.text_len = FIELD_W'(count);
          built_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      // query
      S_Q_CHK: begin
        if (q_bad) begin
          if (!out_valid || out_ready) begin
            out_load = 1'b1;
            out_item.kind = KIND_ERROR;
            out_item.text_len = FIELD_W'(count);
            state_next = S_IDLE;
          end
        end else begin
          r_ra = W'(qa);
          state_next = S_Q_RA;
        end
      end
      S_Q_RA: begin
        ra_next = r_rd;
        r_ra = W'(qb);
        state_next = S_Q_RB;
      end
      S_Q_RB: begin
        rb_next = r_rd;
        qx_next = (ra < r_rd) ? ra : r_rd;
        qy_next = (ra < r_rd) ? r_rd : ra;
        if (qa == qb) begin
          ma_next = count - W'(qa) + W'(1);
          state_next = S_Q_OUT;
        end else begin
          state_next = S_Q_K;
        end
      end
      S_Q_K: begin
        lvl_next = lvl_of(qy - qx);
        n_ra = {LW'(lvl_of(qy - qx)), qx + W'(1)};
        state_next = S_Q_M1;
      end
      S_Q_M1: begin
        ma_next = n_rd;
        n_ra = {LW'(lvl), qy - (W'(1) << lvl) + W'(1)};
        state_next = S_Q_M2;
      end
      S_Q_M2: begin
        ma_next = (ma < n_rd) ? ma : n_rd;
        state_next = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          out_item.kind = KIND_ANSWER;
          out_item.lcp_len = FIELD_W'(ma);
          out_item.rank_a = FIELD_W'(ra);
          out_item.rank_b = FIELD_W'(rb);
          out_item.text_len = FIELD_W'(count);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      built <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      built <= built_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ret <= ret_next; i <= i_next; j <= j_next; tot <= tot_next; acc <= acc_next;
    sp <= sp_next; sr <= sr_next; tp <= tp_next; op <= op_next; tq <= tq_next;
    prev <= prev_next; len <= len_next; yy <= yy_next; ma <= ma_next;
    ych <= ych_next; lvl <= lvl_next; qa <= qa_next; qb <= qb_next;
    ra <= ra_next; rb <= rb_next; qx <= qx_next; qy <= qy_next;
    if (out_load) begin
      out_data <= out_item;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= W'(MAX_LEN)) else $error("text count above capacity");
  a_build_flag: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item.kind == KIND_BUILD) |-> (state == S_DONE))
    else $error("build result outside the done state");
  a_answer_built: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item.kind == KIND_ANSWER) |-> built)
    else $error("answer before build");
  a_rerank_tot: assert property (@(posedge clk) disable iff (rst)
    (state == S_RR_WR) |-> ((W+1)'(tot) < i))
    else $error("rank counter ran ahead of index");
  a_clr_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (i <= (W+1)'(span)))
    else $error("bucket clear past span");

endmodule
`default_nettype wire

// File: sv/salcp_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module salcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for the suffix array and lcp engine: random loads, builds and queries
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import salcp_pkg::*;

  localparam int MAXN = 4096;
  localparam int NLEV = 13;
  localparam int WATCHDOG = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  suffix_array_lcp_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // shadow of the engine state
  int unsigned txt [MAXN+2];
  int unsigned sa [MAXN+2];
  int unsigned rk [MAXN+2];
  int unsigned tmp [MAXN+2];
  int unsigned cnt [MAXN+260];
  int unsigned hgt [MAXN+2];
  int unsigned mn [NLEV][MAXN+2];
  int unsigned lg [MAXN+2];
  int unsigned txt_n = 0;
  bit built = 0;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  bit calm = 0;
  bit hold_send = 0;

  function automatic int unsigned prev_rank(int unsigned p, int unsigned n);
    return (p >= 1 && p <= n) ? tmp[p] : 0;
  endfunction

  function automatic void counting_sort(int unsigned n, int unsigned span);
    int unsigned p, r;
    for (int unsigned i = 0; i <= span; i++) cnt[i] = 0;
    for (int unsigned i = 1; i <= n; i++) cnt[rk[i]]++;
    for (int unsigned i = 1; i <= span; i++) cnt[i] += cnt[i-1];
    for (int unsigned i = n; i >= 1; i--) begin
      p = tmp[i];
      r = rk[p];
      sa[cnt[r]] = p;
      cnt[r]--;
    end
  endfunction

  function automatic void build_index();
    int unsigned n, span, tot, prv, len, y, stp, a, b, p, q;
    n = txt_n;
    span = n > 256 ? n : 256;
    for (int unsigned i = 1; i <= n; i++) begin
      tmp[i] = i;
      rk[i] = txt[i] + 1;
    end
    counting_sort(n, span);
    for (int unsigned j = 1; j <= n; j <<= 1) begin
      tot = 0;
      for (int unsigned i = n - j + 1; i <= n; i++) begin tot++; tmp[tot] = i; end
      for (int unsigned i = 1; i <= n; i++)
        if (sa[i] > j) begin tot++; tmp[tot] = sa[i] - j; end
      counting_sort(n, span);
      for (int unsigned i = 1; i <= n; i++) tmp[i] = rk[i];
      tot = 1;
      rk[sa[1]] = 1;
      for (int unsigned i = 2; i <= n; i++) begin
        p = sa[i-1];
        q = sa[i];
        if (!(tmp[p] == tmp[q] && prev_rank(p + j, n) == prev_rank(q + j, n))) tot++;
        rk[q] = tot;
      end
    end
    // kasai heights
    prv = 0;
    for (int unsigned i = 1; i <= n; i++) begin
      len = 0;
      if (rk[i] != 1) begin
        y = sa[rk[i] - 1];
        len = prv > 0 ? prv - 1 : 0;
        while (i + len <= n && y + len <= n && txt[i+len] == txt[y+len]) len++;
      end
      hgt[i] = len;
      prv = len;
    end
    // sparse min table and log table
    for (int unsigned i = 1; i <= n; i++) mn[0][i] = hgt[sa[i]];
    for (int unsigned k = 1; k < NLEV && (1 << k) <= n; k++) begin
      stp = 1 << (k - 1);
      for (int unsigned i = 1; i + stp <= n; i++) begin
        a = mn[k-1][i];
        b = mn[k-1][i+stp];
        mn[k][i] = a < b ? a : b;
      end
    end
    lg[1] = 0;
    for (int unsigned i = 2; i <= n; i++) lg[i] = lg[i/2] + 1;
    built = 1;
  endfunction

  // advance the shadow by one transaction
  function automatic void predict_item(in_item_t it);
    out_item_t r;
    int unsigned pa, pb, ra, rb, x, y, k, m1, m2;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      if (built) begin txt_n = 0; built = 0; end
      if (txt_n < MAXN) begin txt_n++; txt[txt_n] = 32'(it.text_char); end
      if (it.last_char) begin
        build_index();
        r.kind = KIND_BUILD;
        r.text_len = FIELD_W'(txt_n);
        expected_results.push_back(r);
      end
      return;
    end
    pa = 32'(it.pos_a);
    pb = 32'(it.pos_b);
    r.text_len = FIELD_W'(txt_n);
    if (!built || pa < 1 || pa > txt_n || pb < 1 || pb > txt_n) begin
      r.kind = KIND_ERROR;
    end else begin
      ra = rk[pa];
      rb = rk[pb];
      r.kind = KIND_ANSWER;
      r.rank_a = FIELD_W'(ra);
      r.rank_b = FIELD_W'(rb);
      if (pa == pb) begin
        r.lcp_len = FIELD_W'(txt_n - pa + 1);
      end else begin
        x = ra < rb ? ra : rb;
        y = ra < rb ? rb : ra;
        k = lg[y - x];
        if (k >= NLEV) k = NLEV - 1;
        m1 = mn[k][x+1];
        m2 = mn[k][y - (1 << k) + 1];
        r.lcp_len = FIELD_W'(m1 < m2 ? m1 : m2);
      end
    end
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic in_item_t load_byte(logic [7:0] c, logic lst);
    in_item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.text_char = c;
    it.last_char = lst;
    it.pos_a = FIELD_W'($urandom);
    it.pos_b = FIELD_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t query(int unsigned a, int unsigned b);
    in_item_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.text_char = 8'($urandom);
    it.last_char = 1'($urandom);
    it.pos_a = FIELD_W'(a);
    it.pos_b = FIELD_W'(b);
    return it;
  endfunction

  // one text of n bytes over a small or full alphabet
  task automatic add_text(int unsigned n, int unsigned alpha);
    for (int unsigned i = 1; i <= n; i++)
      pending_items.push_back(load_byte(alpha >= 256 ? 8'($urandom_range(0, 255))
                                                     : 8'(8'h61 + $urandom_range(0, alpha - 1)),
                                        i == n));
  endtask

  // driver
  int idle_in = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (idle_in > 0) begin
        idle_in <= idle_in - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_in <= $urandom_range(1, 18);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_send) begin
        in_data <= pending_items[0];
        predict_item(pending_items.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and output stall
  int idle_out = 0;
  int quiet = 0;
  out_item_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, kind", out_data.kind, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
          if (out_data.lcp_len !== want.lcp_len)
            report_mismatch("lcp_len", out_data.lcp_len, want.lcp_len);
          if (out_data.rank_a !== want.rank_a)
            report_mismatch("rank_a", out_data.rank_a, want.rank_a);
          if (out_data.rank_b !== want.rank_b)
            report_mismatch("rank_b", out_data.rank_b, want.rank_b);
          if (out_data.text_len !== want.text_len)
            report_mismatch("text_len", out_data.text_len, want.text_len);
        end
      end
      if (idle_out > 0) begin
        idle_out <= idle_out - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_out <= $urandom_range(1, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      // watchdog on cycles without any transaction
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    // directed: queries before a build, tiny texts, zero and top bytes
    pending_items.push_back(query(1, 1));
    pending_items.push_back(query(0, 8191));
    pending_items.push_back(load_byte(8'hff, 1'b1));
    pending_items.push_back(query(1, 1));
    pending_items.push_back(query(1, 2));
    pending_items.push_back(query(0, 1));
    pending_items.push_back(load_byte(8'h00, 1'b0));
    pending_items.push_back(load_byte(8'hff, 1'b0));
    pending_items.push_back(load_byte(8'h00, 1'b0));
    pending_items.push_back(load_byte(8'hff, 1'b0));
    pending_items.push_back(load_byte(8'h00, 1'b1));
    pending_items.push_back(query(1, 3));
    pending_items.push_back(query(2, 4));
    pending_items.push_back(query(5, 5));
    pending_items.push_back(query(1, 5));
    pending_items.push_back(query(5, 6));
    pending_items.push_back(query(8191, 1));
    pending_items.push_back(query(4096, 4096));
    for (int i = 0; i < 6; i++) pending_items.push_back(load_byte(8'h61, i == 5));
    pending_items.push_back(query(1, 2));
    pending_items.push_back(query(6, 1));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // random texts, each followed by queries
    for (int t = 0; t < 40; t++) begin
      if (t == 20) begin
        // hold sends until everything outstanding has drained
        wait (pending_items.size() == 0);
        hold_send = 1;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        hold_send = 0;
      end
      if (t == 34) calm = 1;
      n = (t == 10) ? 300 : $urandom_range(1, 24);
      add_text(n, (t % 3 == 0) ? 256 : $urandom_range(1, 3));
      for (int q = 0; q < 16; q++) begin
        case ($urandom_range(0, 7))
          0: pending_items.push_back(query($urandom_range(0, 8191), $urandom_range(0, 8191)));
          1: begin
            int unsigned p;
            p = $urandom_range(1, n);
            pending_items.push_back(query(p, p));
          end
          2: pending_items.push_back(query($urandom_range(0, n + 1), $urandom_range(0, n + 1)));
          default: pending_items.push_back(query($urandom_range(1, n), $urandom_range(1, n)));
        endcase
      end
      wait (pending_items.size() < 4);
    end
    // drain everything still in flight
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
